>>> rtl/eett_pkg.sv
// ----------------------------------------------------------------------------
// eett_pkg: shared types and constants of the earliest event timer table
// widths, operation and status codes, the front-to-back request record and the result record
// ----------------------------------------------------------------------------
package eett_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int TIME_BITS   = 32;
    localparam int HANDLE_BITS = 16;
    localparam int STREAM_BITS = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    localparam logic [2:0] FUNC_ADD        = 3'd0;
    localparam logic [2:0] FUNC_REPORT     = 3'd1;
    localparam logic [2:0] FUNC_FIND       = 3'd2;
    localparam logic [2:0] FUNC_DEL_HANDLE = 3'd3;
    localparam logic [2:0] FUNC_DEL_STREAM = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [1:0] RPT_BAD_EVENT  = 2'd1;
    localparam logic [1:0] RPT_BAD_STREAM = 2'd2;

    // classified operation handed from the front to the back
    typedef enum logic [5:0] {
        OP_ADD        = 6'b000001,
        OP_REPORT     = 6'b000010,
        OP_FIND       = 6'b000100,
        OP_DEL_HANDLE = 6'b001000,
        OP_DEL_STREAM = 6'b010000,
        OP_NOP        = 6'b100000
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic                   recurring;
        logic [HANDLE_BITS-1:0] handle;
        logic [STREAM_BITS-1:0] stream;
        logic [TIME_BITS-1:0]   due_time;
        logic [TIME_BITS-1:0]   period;
        logic [1:0]             report_status;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] out_handle;
        logic [STREAM_BITS-1:0] out_stream;
        logic [TIME_BITS-1:0]   out_time;
        logic                   next_valid;
        logic [TIME_BITS-1:0]   next_time;
        logic [HANDLE_BITS-1:0] next_handle;
    } t_res;

endpackage

>>> rtl/eett_front.sv
// ----------------------------------------------------------------------------
// eett_front: request decode
// classifies each request and works out due time and period of an add
// ----------------------------------------------------------------------------
module eett_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_recurring_enable,
    input  logic [2:0]                     i_func,
    input  logic [eett_pkg::HANDLE_BITS-1:0] i_handle,
    input  logic [eett_pkg::STREAM_BITS-1:0] i_stream,
    input  logic [eett_pkg::TIME_BITS-1:0] i_event_time,
    input  logic                           i_recurring_request,
    input  logic [eett_pkg::TIME_BITS-1:0] i_current_time,
    input  logic [1:0]                     i_report_status,
    input  logic                           i_valid,
    output logic                           o_ready,
    output logic                           o_valid,
    output eett_pkg::t_req                 o_req,
    input  logic                           i_ready
);

    eett_pkg::t_req r_req;
    logic           r_valid;
    eett_pkg::t_req n_req;
    logic           rec;

    always_comb begin
        rec             = i_recurring_enable & i_recurring_request;
        n_req.recurring = rec;
        n_req.handle    = i_handle;
        n_req.stream    = i_stream;
        n_req.period    = rec ? i_event_time : '0;
        n_req.due_time  = rec ? i_current_time + i_event_time : i_event_time;
        n_req.report_status = i_report_status;
        unique case (i_func)
            eett_pkg::FUNC_ADD:        n_req.op = eett_pkg::OP_ADD;
            eett_pkg::FUNC_REPORT:     n_req.op = eett_pkg::OP_REPORT;
            eett_pkg::FUNC_FIND:       n_req.op = eett_pkg::OP_FIND;
            eett_pkg::FUNC_DEL_HANDLE: n_req.op = eett_pkg::OP_DEL_HANDLE;
            eett_pkg::FUNC_DEL_STREAM: n_req.op = eett_pkg::OP_DEL_STREAM;
            default:                   n_req.op = eett_pkg::OP_NOP;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

endmodule

>>> rtl/eett_queue.sv
// ----------------------------------------------------------------------------
// eett_queue: request queue
// short fifo between decode and the table engine
// ----------------------------------------------------------------------------
module eett_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  eett_pkg::t_req i_req,
    output logic           o_ready,
    output logic           o_valid,
    output eett_pkg::t_req o_req,
    input  logic           i_ready
);

    eett_pkg::t_req r_mem [eett_pkg::QUEUE_DEPTH];
    logic [eett_pkg::QPTR_BITS-1:0] r_wp, r_rp;
    logic [eett_pkg::QPTR_BITS:0]   r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != eett_pkg::QUEUE_DEPTH[eett_pkg::QPTR_BITS:0];
    assign o_valid = r_cnt != '0;
    assign o_req   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{eett_pkg::QPTR_BITS{1'b0}}, push}
                           - {{eett_pkg::QPTR_BITS{1'b0}}, pop};
        end
        if (push) r_mem[r_wp] <= i_req;
    end

endmodule

>>> rtl/eett_back.sv
// ----------------------------------------------------------------------------
// eett_back: table engine
// slot table with a one-slot-per-cycle scan for lookup, purge and new minimum
// ----------------------------------------------------------------------------
module eett_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  eett_pkg::t_req i_req,
    output logic           o_ready,
    output logic           o_valid,
    output eett_pkg::t_res o_res,
    input  logic           i_ready
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIND  = 5'b00010,
        S_APPLY = 5'b00100,
        S_MIN   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    eett_pkg::t_req r_req;
    logic [eett_pkg::SLOTS-1:0] r_valid_bits;
    logic [eett_pkg::HANDLE_BITS-1:0] r_handle [eett_pkg::SLOTS];
    logic [eett_pkg::STREAM_BITS-1:0] r_stream [eett_pkg::SLOTS];
    logic [eett_pkg::TIME_BITS-1:0]   r_due    [eett_pkg::SLOTS];
    logic [eett_pkg::TIME_BITS-1:0]   r_period [eett_pkg::SLOTS];
    logic [eett_pkg::SLOTS-1:0]       r_rec;

    logic [eett_pkg::SLOT_BITS-1:0] r_cnt;
    logic                           r_hit;
    logic [eett_pkg::SLOT_BITS-1:0] r_sel;
    logic [eett_pkg::SLOT_BITS-1:0] r_min_idx;
    logic                           r_min_valid;
    logic [eett_pkg::TIME_BITS-1:0] r_min_time;
    eett_pkg::t_res r_res;
    logic          r_out_valid;

    logic [eett_pkg::SLOT_BITS-1:0] idx;
    logic          match;

    assign idx     = r_cnt;
    // the result register doubles as the work register, so wait until it is taken
    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    // slot match for the lookup pass
    always_comb begin
        match = 1'b0;
        unique case (r_req.op)
            eett_pkg::OP_ADD:    match = !r_valid_bits[idx];
            eett_pkg::OP_FIND, eett_pkg::OP_DEL_HANDLE:
                match = r_valid_bits[idx] && r_handle[idx] == r_req.handle;
            default:             match = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid_bits <= '0;
            r_min_valid  <= 1'b0;
            r_min_idx    <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_hit        <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out_valid) begin
                        if (i_ready) r_out_valid <= 1'b0;
                    end else if (i_valid) begin
                        r_req   <= i_req;
                        r_cnt   <= '0;
                        r_hit   <= 1'b0;
                        r_res   <= '0;
                        r_state <= (i_req.op == eett_pkg::OP_ADD
                                 || i_req.op == eett_pkg::OP_FIND
                                 || i_req.op == eett_pkg::OP_DEL_HANDLE)
                                 ? S_FIND : S_APPLY;
                    end
                end
                S_FIND: begin
                    if (match && !r_hit) begin
                        r_hit <= 1'b1;
                        r_sel <= idx;
                    end
                    // the count wraps back to zero after the last slot
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == eett_pkg::LAST_SLOT) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    // a stream purge visits every slot; other operations go on to S_MIN
                    r_min_valid <= 1'b0;
                    r_min_idx   <= '0;
                    unique case (r_req.op)
                        eett_pkg::OP_ADD: begin
                            r_state <= S_MIN;
                            if (!r_hit) begin
                                r_res.status <= eett_pkg::ST_FULL;
                            end else begin
                                r_valid_bits[r_sel] <= 1'b1;
                                r_handle[r_sel]     <= r_req.handle;
                                r_stream[r_sel]     <= r_req.stream;
                                r_due[r_sel]        <= r_req.due_time;
                                r_period[r_sel]     <= r_req.period;
                                r_rec[r_sel]        <= r_req.recurring;
                                r_res.out_handle    <= r_req.handle;
                                r_res.out_stream    <= r_req.stream;
                                r_res.out_time      <= r_req.due_time;
                            end
                        end
                        eett_pkg::OP_FIND, eett_pkg::OP_DEL_HANDLE: begin
                            r_state <= S_MIN;
                            if (!r_hit) begin
                                r_res.status <= eett_pkg::ST_NOT_FOUND;
                            end else begin
                                r_res.out_handle <= r_handle[r_sel];
                                r_res.out_stream <= r_stream[r_sel];
                                r_res.out_time   <= r_due[r_sel];
                                if (r_req.op == eett_pkg::OP_DEL_HANDLE)
                                    r_valid_bits[r_sel] <= 1'b0;
                            end
                        end
                        eett_pkg::OP_REPORT: begin
                            if (!r_min_valid) begin
                                r_res.status <= eett_pkg::ST_EMPTY;
                                r_state      <= S_MIN;
                            end else begin
                                r_res.out_handle <= r_handle[r_min_idx];
                                r_res.out_stream <= r_stream[r_min_idx];
                                r_res.out_time   <= r_due[r_min_idx];
                                priority if (r_req.report_status
                                             == eett_pkg::RPT_BAD_EVENT) begin
                                    r_valid_bits[r_min_idx] <= 1'b0;
                                    r_state                 <= S_MIN;
                                end else if (r_req.report_status
                                             == eett_pkg::RPT_BAD_STREAM) begin
                                    // purge the stream of the reported event next
                                    r_req.op     <= eett_pkg::OP_DEL_STREAM;
                                    r_req.stream <= r_stream[r_min_idx];
                                end else if (r_rec[r_min_idx]) begin
                                    r_due[r_min_idx] <= r_due[r_min_idx]
                                                      + r_period[r_min_idx];
                                    r_state          <= S_MIN;
                                end else begin
                                    r_valid_bits[r_min_idx] <= 1'b0;
                                    r_state                 <= S_MIN;
                                end
                            end
                        end
                        eett_pkg::OP_DEL_STREAM: begin
                            if (r_valid_bits[idx] && r_stream[idx] == r_req.stream)
                                r_valid_bits[idx] <= 1'b0;
                            // equals the reported stream when a report started the purge
                            r_res.out_stream <= r_req.stream;
                            r_cnt            <= r_cnt + 1'b1;
                            if (r_cnt == eett_pkg::LAST_SLOT) r_state <= S_MIN;
                        end
                        default: r_state <= S_MIN;
                    endcase
                end
                S_MIN: begin
                    if (r_valid_bits[idx] && (!r_min_valid || r_due[idx] < r_min_time)) begin
                        r_min_valid <= 1'b1;
                        r_min_idx   <= idx;
                        r_min_time  <= r_due[idx];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == eett_pkg::LAST_SLOT) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out_valid       <= 1'b1;
                    r_res.next_valid  <= r_min_valid;
                    r_res.next_time   <= r_min_valid ? r_due[r_min_idx] : '0;
                    r_res.next_handle <= r_min_valid ? r_handle[r_min_idx] : '0;
                    r_state           <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_min_valid_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_min_valid) |-> r_valid_bits[r_min_idx])
        else $error("earliest slot not valid");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid)
        else $error("result dropped");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !o_ready)
        else $error("ready while busy");

endmodule

>>> rtl/earliest_event_timer_table.sv
// path: decode register and request queue, then in the table engine a 16-slot lookup
// pass for add, find and delete by handle, or a 16-slot purge pass for delete by stream
// and a report that purges a stream, then a 16-slot minimum scan and the result step
// one request at a time in the table engine, which takes the next request the cycle
// after a result is taken
// reset: synchronous active-low; clears slot valid bits, earliest mark and recurring enable
// ----------------------------------------------------------------------------
// earliest_event_timer_table: pending timer events with earliest-due tracking
// stream ports, decode front, request queue and slot table engine
// ----------------------------------------------------------------------------
module earliest_event_timer_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[2:0], event_handle[18:3], stream_id[22:19], event_time[54:23],
    // recurring_request[55], stream_current_time[87:56], report_status[89:88]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], out_handle[17:2], out_stream[21:18], out_time[53:22],
    // next_valid[54], next_time[86:55], next_handle[102:87]
    output logic [103:0] m_axis_tdata
);

    logic r_rec_en;
    logic f_valid, f_ready, q_valid, q_ready;
    eett_pkg::t_req f_req, q_req;
    eett_pkg::t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_rec_en <= i_cfg_wdata;
        end
    end

    eett_front u_front (
        .i_clk, .i_rst_n,
        .i_recurring_enable (r_rec_en),
        .i_func             (s_axis_tdata[2:0]),
        .i_handle           (s_axis_tdata[18:3]),
        .i_stream           (s_axis_tdata[22:19]),
        .i_event_time       (s_axis_tdata[54:23]),
        .i_recurring_request(s_axis_tdata[55]),
        .i_current_time     (s_axis_tdata[87:56]),
        .i_report_status    (s_axis_tdata[89:88]),
        .i_valid            (s_axis_tvalid),
        .o_ready            (s_axis_tready),
        .o_valid            (f_valid),
        .o_req              (f_req),
        .i_ready            (f_ready)
    );

    eett_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid (f_valid), .i_req (f_req), .o_ready (f_ready),
        .o_valid (q_valid), .o_req (q_req), .i_ready (q_ready)
    );

    eett_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (q_valid), .i_req (q_req), .o_ready (q_ready),
        .o_valid (m_axis_tvalid), .o_res (res), .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, res.next_handle, res.next_time, res.next_valid,
                           res.out_time, res.out_stream, res.out_handle, res.status};

endmodule

>>> sim/eett_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eett_checker: result checker for the earliest event timer table
// follows accepted requests and config writes, predicts each response and
// compares it field by field with what leaves the master side
// ----------------------------------------------------------------------------
module eett_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [95:0]  i_req_data,
    input  logic         i_rsp_valid,
    input  logic         i_rsp_ready,
    input  logic [103:0] i_rsp_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_rsp_count
);

    // local copy of the table
    logic                             tbl_valid  [eett_pkg::SLOTS];
    logic [eett_pkg::HANDLE_BITS-1:0] tbl_handle [eett_pkg::SLOTS];
    logic [eett_pkg::STREAM_BITS-1:0] tbl_stream [eett_pkg::SLOTS];
    logic [eett_pkg::TIME_BITS-1:0]   tbl_due    [eett_pkg::SLOTS];
    logic [eett_pkg::TIME_BITS-1:0]   tbl_period [eett_pkg::SLOTS];
    logic                             tbl_rec    [eett_pkg::SLOTS];
    logic                             rec_enable;
    eett_pkg::t_res                   expected_rsp[$];

    function automatic int earliest_slot();
        int e;
        e = -1;
        for (int i = 0; i < eett_pkg::SLOTS; i++) begin
            if (tbl_valid[i] && (e < 0 || tbl_due[i] < tbl_due[e])) begin
                e = i;
            end
        end
        return e;
    endfunction

    function automatic int lookup_handle(logic [eett_pkg::HANDLE_BITS-1:0] h);
        for (int i = 0; i < eett_pkg::SLOTS; i++) begin
            if (tbl_valid[i] && tbl_handle[i] == h) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic apply_request(logic [95:0] d);
        logic [2:0]                       fn;
        logic [eett_pkg::HANDLE_BITS-1:0] h;
        logic [eett_pkg::STREAM_BITS-1:0] s;
        logic [eett_pkg::TIME_BITS-1:0]   et;
        logic                             rq;
        logic [eett_pkg::TIME_BITS-1:0]   ct;
        logic [1:0]                       rs;
        logic [eett_pkg::STREAM_BITS-1:0] ps;
        eett_pkg::t_res                   r;
        int                               k;
        fn = d[2:0];
        h  = d[18:3];
        s  = d[22:19];
        et = d[54:23];
        rq = d[55];
        ct = d[87:56];
        rs = d[89:88];
        r  = '0;
        k  = -1;
        case (fn)
            eett_pkg::FUNC_ADD: begin
                for (int i = eett_pkg::SLOTS - 1; i >= 0; i--) begin
                    if (!tbl_valid[i]) k = i;
                end
                if (k < 0) begin
                    r.status = eett_pkg::ST_FULL;
                end else begin
                    tbl_valid[k]  = 1'b1;
                    tbl_handle[k] = h;
                    tbl_stream[k] = s;
                    tbl_rec[k]    = rec_enable && rq;
                    tbl_period[k] = tbl_rec[k] ? et : '0;
                    tbl_due[k]    = tbl_rec[k] ? ct + et : et;
                    r.out_handle  = h;
                    r.out_stream  = s;
                    r.out_time    = tbl_due[k];
                end
            end
            eett_pkg::FUNC_REPORT: begin
                k = earliest_slot();
                if (k < 0) begin
                    r.status = eett_pkg::ST_EMPTY;
                end else begin
                    r.out_handle = tbl_handle[k];
                    r.out_stream = tbl_stream[k];
                    r.out_time   = tbl_due[k];
                    if (rs == eett_pkg::RPT_BAD_EVENT) begin
                        tbl_valid[k] = 1'b0;
                    end else if (rs == eett_pkg::RPT_BAD_STREAM) begin
                        ps = tbl_stream[k];
                        for (int i = 0; i < eett_pkg::SLOTS; i++) begin
                            if (tbl_stream[i] == ps) tbl_valid[i] = 1'b0;
                        end
                    end else if (tbl_rec[k]) begin
                        tbl_due[k] = tbl_due[k] + tbl_period[k];
                    end else begin
                        tbl_valid[k] = 1'b0;
                    end
                end
            end
            eett_pkg::FUNC_FIND, eett_pkg::FUNC_DEL_HANDLE: begin
                k = lookup_handle(h);
                if (k < 0) begin
                    r.status = eett_pkg::ST_NOT_FOUND;
                end else begin
                    r.out_handle = tbl_handle[k];
                    r.out_stream = tbl_stream[k];
                    r.out_time   = tbl_due[k];
                    if (fn == eett_pkg::FUNC_DEL_HANDLE) tbl_valid[k] = 1'b0;
                end
            end
            eett_pkg::FUNC_DEL_STREAM: begin
                for (int i = 0; i < eett_pkg::SLOTS; i++) begin
                    if (tbl_stream[i] == s) tbl_valid[i] = 1'b0;
                end
                r.out_stream = s;
            end
            default: ;
        endcase
        k = earliest_slot();
        if (k >= 0) begin
            r.next_valid  = 1'b1;
            r.next_time   = tbl_due[k];
            r.next_handle = tbl_handle[k];
        end
        expected_rsp.push_back(r);
    endtask

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    task automatic check_response(logic [103:0] d);
        eett_pkg::t_res e;
        if (expected_rsp.size() == 0) begin
            $error("response with no request waiting: 0x%0h", d);
            o_errors++;
            return;
        end
        e = expected_rsp.pop_front();
        compare_field("status", 32'(e.status), 32'(d[1:0]));
        compare_field("out_handle", 32'(e.out_handle), 32'(d[17:2]));
        compare_field("out_stream", 32'(e.out_stream), 32'(d[21:18]));
        compare_field("out_time", e.out_time, d[53:22]);
        compare_field("next_valid", 32'(e.next_valid), 32'(d[54]));
        compare_field("next_time", e.next_time, d[86:55]);
        compare_field("next_handle", 32'(e.next_handle), 32'(d[102:87]));
    endtask

    initial begin
        o_errors    = 0;
        o_rsp_count = 0;
        rec_enable  = 1'b0;
        for (int i = 0; i < eett_pkg::SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_stream[i] = '0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_enable = 1'b0;
            for (int i = 0; i < eett_pkg::SLOTS; i++) tbl_valid[i] = 1'b0;
        end else begin
            if (i_cfg_we) rec_enable = i_cfg_wdata;
            if (i_req_valid && i_req_ready) apply_request(i_req_data);
            if (i_rsp_valid && i_rsp_ready) begin
                check_response(i_rsp_data);
                o_rsp_count++;
            end
        end
        o_pending = expected_rsp.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the earliest event timer table
// directed and random requests with random idling on both sides, a long
// response hold-off and config changes between phases; checking is done by
// eett_checker
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    int errors;
    int pending;
    int rsp_count;
    int req_count;
    int idle_cycles;
    bit src_idle;
    bit sink_idle;
    bit hold_sink;

    earliest_event_timer_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    eett_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_rsp_count (rsp_count)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // response side: random back-pressure unless held off or idling disabled
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_sink) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !sink_idle || ($urandom_range(99) >= 35);
        end
    end

    // watchdog on cycles with no handshake, outside reset and the response hold-off
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_sink
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [95:0] pack_req(logic [2:0] fn, logic [15:0] h, logic [3:0] s,
            logic [31:0] et, logic rq, logic [31:0] ct, logic [1:0] rs);
        return {6'd0, rs, ct, rq, et, s, h, fn};
    endfunction

    task automatic send(logic [95:0] d);
        if (src_idle) begin
            while ($urandom_range(99) < 35) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        req_count++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // random request, weighted towards adds and reports; handles kept in a
    // narrow pool so that finds and deletes hit often
    task automatic send_random();
        logic [2:0]  fn;
        logic [15:0] h;
        logic [31:0] et;
        logic [31:0] ct;
        int          p;
        p = $urandom_range(99);
        if (p < 35)      fn = eett_pkg::FUNC_ADD;
        else if (p < 65) fn = eett_pkg::FUNC_REPORT;
        else if (p < 78) fn = eett_pkg::FUNC_FIND;
        else if (p < 90) fn = eett_pkg::FUNC_DEL_HANDLE;
        else if (p < 96) fn = eett_pkg::FUNC_DEL_STREAM;
        else             fn = 3'($urandom_range(7));
        h  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
        et = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
        ct = ($urandom_range(1) == 0) ? $urandom : $urandom_range(1000);
        send(pack_req(fn, h, 4'($urandom_range(15)), et, 1'($urandom), ct,
                      2'($urandom_range(3))));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        req_count     = 0;
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        hold_sink     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, unknown handle, no-op codes
        send(pack_req(eett_pkg::FUNC_REPORT, 16'h0, 4'h0, 32'h0, 1'b0, 32'h0, 2'd0));
        send(pack_req(eett_pkg::FUNC_FIND, 16'hffff, 4'h0, 32'h0, 1'b0, 32'h0, 2'd0));
        send(pack_req(3'd5, 16'hffff, 4'hf, 32'hffffffff, 1'b1, 32'hffffffff, 2'd3));
        send(pack_req(3'd7, 16'h0, 4'h0, 32'h0, 1'b0, 32'h0, 2'd0));
        // recurring request while disabled is stored as one-shot
        send(pack_req(eett_pkg::FUNC_ADD, 16'hffff, 4'hf, 32'hffffffff, 1'b1, 32'hffffffff,
                      2'd0));
        send(pack_req(eett_pkg::FUNC_ADD, 16'h0001, 4'h3, 32'h0, 1'b0, 32'h0, 2'd0));
        send(pack_req(eett_pkg::FUNC_ADD, 16'h0001, 4'h3, 32'h0, 1'b0, 32'h0, 2'd0));
        send(pack_req(eett_pkg::FUNC_FIND, 16'h0001, 4'h0, 32'h0, 1'b0, 32'h0, 2'd0));
        send(pack_req(eett_pkg::FUNC_DEL_HANDLE, 16'h0001, 4'h0, 32'h0, 1'b0, 32'h0, 2'd0));
        send(pack_req(eett_pkg::FUNC_REPORT, 16'h0, 4'h0, 32'h0, 1'b0, 32'h0, 2'd3));
        send(pack_req(eett_pkg::FUNC_DEL_STREAM, 16'h0, 4'h9, 32'h0, 1'b0, 32'h0, 2'd0));
        write_cfg(1'b1);
        // recurring with wrapping due time, then fill the table to overflow
        send(pack_req(eett_pkg::FUNC_ADD, 16'h00aa, 4'h5, 32'hfffffff0, 1'b1, 32'h20, 2'd0));
        for (int i = 0; i < 16; i++) begin
            send(pack_req(eett_pkg::FUNC_ADD, 16'(i), 4'(i % 3), 32'(i * 7), 1'(i), 32'h100,
                          2'd0));
        end
        send(pack_req(eett_pkg::FUNC_REPORT, 16'h0, 4'h0, 32'h0, 1'b0, 32'h0, 2'd0));
        send(pack_req(eett_pkg::FUNC_REPORT, 16'h0, 4'h0, 32'h0, 1'b0, 32'h0,
                      eett_pkg::RPT_BAD_EVENT));
        send(pack_req(eett_pkg::FUNC_REPORT, 16'h0, 4'h0, 32'h0, 1'b0, 32'h0,
                      eett_pkg::RPT_BAD_STREAM));
        send(pack_req(eett_pkg::FUNC_DEL_STREAM, 16'h0, 4'h1, 32'h0, 1'b0, 32'h0, 2'd0));

        // sender pause until everything is back, then random phases
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (600) @(posedge i_clk);
                        hold_sink = 1'b0;
                    end
                    for (int n = 0; n < 20; n++) send_random();
                join
            end
            src_idle  = (ph != 2);
            sink_idle = (ph != 2);
            for (int n = 0; n < 170; n++) send_random();
            write_cfg(1'(ph % 2));
        end
        drain();

        $display("ran %0d requests and checked %0d responses: all operations, full and",
                 req_count, rsp_count);
        $display("empty table, recurring wrap, stream purges, back-pressure hold-off");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> earliest_event_timer_table.f
rtl/eett_pkg.sv
rtl/eett_front.sv
rtl/eett_queue.sv
rtl/eett_back.sv
rtl/earliest_event_timer_table.sv
sim/eett_checker.sv
sim/tb_top.sv
